// ===== rtl/sorted_list_insert_remove_top_defines.svh =====
// Assertion helpers for the sorted list block.
`ifndef SORTED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH
`define SORTED_LIST_INSERT_REMOVE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLRI_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("sorted list assertion failed");

// Next-cycle implication, disabled during reset.
`define SLRI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("sorted list assertion failed");

`endif

// ===== rtl/slri_pkg.sv =====
// ----------------------------------------------------------------------------
// slri_pkg
// Command and result word types and status codes of the sorted list block.
// ----------------------------------------------------------------------------
package slri_pkg;

  localparam int unsigned ScoreBits = 32;
  localparam int unsigned TagInBits = 32;
  localparam int unsigned CountBits = 5;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           opcode;
    logic        [TagInBits-1:0]   name_tag;
    logic signed [ScoreBits-1:0]   score;
  } cmd_t;

  typedef struct packed {
    status_e                 status;
    logic [CountBits-1:0]    entry_count;
  } result_t;

endpackage

// ===== rtl/slri_mem.sv =====
// ----------------------------------------------------------------------------
// slri_mem
// Entry memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module slri_mem #(
  parameter int unsigned Depth = 16,
  parameter int unsigned Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/slri_ctrl.sv =====
// ----------------------------------------------------------------------------
// slri_ctrl
// Sequencer: scans the entry memory, shifts entries and keeps the fill count.
// ----------------------------------------------------------------------------
module slri_ctrl #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned StTagBits = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  slri_pkg::cmd_t                    cmd_i,
  output logic                              result_valid_o,
  output slri_pkg::result_t                 result_o,
  output logic                              mem_we_o,
  output logic [$clog2(CAPACITY)-1:0]       mem_waddr_o,
  output logic [StTagBits+31:0]             mem_wdata_o,
  output logic [$clog2(CAPACITY)-1:0]       mem_raddr_o,
  input  logic [StTagBits+31:0]             mem_rdata_i
);

  import slri_pkg::*;

  localparam int unsigned AddrW = $clog2(CAPACITY);
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CapCnt = CntW'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_LAST,
    S_RM_SCAN,
    S_RM_SHIFT
  } state_e;

  state_e                   state_q, state_d;
  logic [CntW-1:0]          fill_q, fill_d;
  logic [AddrW-1:0]         rd_q, rd_d;
  logic [StTagBits-1:0]     key_tag_q, key_tag_d;
  logic signed [31:0]       key_score_q, key_score_d;
  logic                     res_valid_q, res_valid_d;
  status_e                  res_status_q, res_status_d;
  logic [CntW-1:0]          res_count_q, res_count_d;

  logic                     accept;
  logic [StTagBits-1:0]     rd_tag;
  logic signed [31:0]       rd_score;
  logic                     rd_last;
  logic [CntW-1:0]          fill_m1;
  logic [31:0]              count_ext;

  assign accept   = start && !busy;
  assign rd_tag   = mem_rdata_i[StTagBits+31:32];
  assign rd_score = $signed(mem_rdata_i[31:0]);
  assign fill_m1  = fill_q - CntW'(1);
  assign rd_last  = (CntW'(rd_q) == fill_m1);

  always_comb begin
    state_d      = state_q;
    fill_d       = fill_q;
    rd_d         = rd_q;
    key_tag_d    = key_tag_q;
    key_score_d  = key_score_q;
    res_valid_d  = 1'b0;
    res_status_d = res_status_q;
    res_count_d  = res_count_q;
    mem_we_o     = 1'b0;
    mem_waddr_o  = '0;
    mem_wdata_o  = {key_tag_q, key_score_q};
    mem_raddr_o  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          key_tag_d   = cmd_i.name_tag[StTagBits-1:0];
          key_score_d = cmd_i.score;
          if (cmd_i.opcode == OP_INSERT) begin
            if (fill_q == CapCnt) begin
              res_valid_d  = 1'b1;
              res_status_d = ST_FULL;
              res_count_d  = fill_q;
            end else if (fill_q == '0) begin
              mem_we_o     = 1'b1;
              mem_waddr_o  = '0;
              mem_wdata_o  = {cmd_i.name_tag[StTagBits-1:0], cmd_i.score};
              fill_d       = fill_q + CntW'(1);
              res_valid_d  = 1'b1;
              res_status_d = ST_DONE;
              res_count_d  = fill_d;
            end else begin
              // Walk down from the last entry.
              mem_raddr_o = fill_m1[AddrW-1:0];
              rd_d        = fill_m1[AddrW-1:0];
              state_d     = S_INS;
            end
          end else begin
            if (fill_q == '0) begin
              res_valid_d  = 1'b1;
              res_status_d = ST_NOT_FOUND;
              res_count_d  = fill_q;
            end else begin
              mem_raddr_o = '0;
              rd_d        = '0;
              state_d     = S_RM_SCAN;
            end
          end
        end
      end

      S_INS: begin
        // Read ahead one entry lower; unused data is dropped.
        mem_raddr_o = rd_q - AddrW'(1);
        rd_d        = rd_q - AddrW'(1);
        mem_we_o    = 1'b1;
        mem_waddr_o = rd_q + AddrW'(1);
        if (rd_score > key_score_q) begin
          mem_wdata_o = mem_rdata_i;
          if (rd_q == '0) begin
            state_d = S_INS_LAST;
          end
        end else begin
          mem_wdata_o  = {key_tag_q, key_score_q};
          fill_d       = fill_q + CntW'(1);
          res_valid_d  = 1'b1;
          res_status_d = ST_DONE;
          res_count_d  = fill_d;
          state_d      = S_IDLE;
        end
      end

      S_INS_LAST: begin
        mem_we_o     = 1'b1;
        mem_waddr_o  = '0;
        mem_wdata_o  = {key_tag_q, key_score_q};
        fill_d       = fill_q + CntW'(1);
        res_valid_d  = 1'b1;
        res_status_d = ST_DONE;
        res_count_d  = fill_d;
        state_d      = S_IDLE;
      end

      S_RM_SCAN: begin
        mem_raddr_o = rd_q + AddrW'(1);
        rd_d        = rd_q + AddrW'(1);
        if (rd_tag == key_tag_q && rd_score == key_score_q) begin
          if (rd_last) begin
            fill_d       = fill_m1;
            res_valid_d  = 1'b1;
            res_status_d = ST_DONE;
            res_count_d  = fill_d;
            state_d      = S_IDLE;
          end else begin
            state_d = S_RM_SHIFT;
          end
        end else if (rd_last) begin
          res_valid_d  = 1'b1;
          res_status_d = ST_NOT_FOUND;
          res_count_d  = fill_q;
          state_d      = S_IDLE;
        end
      end

      S_RM_SHIFT: begin
        // Move the arriving entry one place toward the front.
        mem_we_o    = 1'b1;
        mem_waddr_o = rd_q - AddrW'(1);
        mem_wdata_o = mem_rdata_i;
        mem_raddr_o = rd_q + AddrW'(1);
        rd_d        = rd_q + AddrW'(1);
        if (rd_last) begin
          fill_d       = fill_m1;
          res_valid_d  = 1'b1;
          res_status_d = ST_DONE;
          res_count_d  = fill_d;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fill_q       <= '0;
      res_valid_q  <= 1'b0;
      res_status_q <= ST_DONE;
      res_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      fill_q       <= fill_d;
      res_valid_q  <= res_valid_d;
      res_status_q <= res_status_d;
      res_count_q  <= res_count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q        <= rd_d;
    key_tag_q   <= key_tag_d;
    key_score_q <= key_score_d;
  end

  assign busy                 = (state_q != S_IDLE);
  assign count_ext            = 32'(res_count_q);
  assign result_valid_o       = res_valid_q;
  assign result_o.status      = res_status_q;
  assign result_o.entry_count = count_ext[CountBits-1:0];

endmodule

// ===== rtl/sorted_list_insert_remove_top.sv =====
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top
// Bounded table of tag/score entries kept in ascending score order.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low. Each command gives
// exactly one result word, shown for one cycle with result_valid_o high; the
// receiver must take it then. An insert into a full or an empty table and a
// remove from an empty table are answered from the idle state and busy stays
// low. Other commands run in busy states: an insert walks down from the last
// entry, and a remove makes a single forward pass, since the search and the
// shift share it. The entry memory moves one entry per cycle through its
// single read port and single write port. Entries with equal scores keep
// their arrival order; only the low TAG_BITS bits of a name tag are stored
// and compared.
`include "sorted_list_insert_remove_top_defines.svh"

module sorted_list_insert_remove_top #(
  parameter int unsigned CAPACITY = 16,
  parameter int unsigned TAG_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  slri_pkg::cmd_t      cmd_i,
  output logic                result_valid_o,
  output slri_pkg::result_t   result_o
);

  import slri_pkg::*;

  localparam int unsigned StTagBits = (TAG_BITS < TagInBits) ? TAG_BITS : TagInBits;
  localparam int unsigned EntryW    = StTagBits + ScoreBits;
  localparam int unsigned AddrW     = $clog2(CAPACITY);
  localparam logic [CountBits-1:0] CapLow = CountBits'(CAPACITY);

  logic              mem_we;
  logic [AddrW-1:0]  mem_waddr;
  logic [EntryW-1:0] mem_wdata;
  logic [AddrW-1:0]  mem_raddr;
  logic [EntryW-1:0] mem_rdata;

  slri_ctrl #(
    .CAPACITY (CAPACITY),
    .StTagBits(StTagBits)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .cmd_i         (cmd_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o),
    .mem_we_o      (mem_we),
    .mem_waddr_o   (mem_waddr),
    .mem_wdata_o   (mem_wdata),
    .mem_raddr_o   (mem_raddr),
    .mem_rdata_i   (mem_rdata)
  );

  slri_mem #(
    .Depth(CAPACITY),
    .Width(EntryW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  `SLRI_ASSERT_NOW(a_word_not_busy, clk_i, rst_ni, result_valid_o, !busy)
  `SLRI_ASSERT_NEXT(a_accept_progress, clk_i, rst_ni, start && !busy,
                    busy || result_valid_o)
  `SLRI_ASSERT_NOW(a_full_at_capacity, clk_i, rst_ni,
                   result_valid_o && result_o.status == ST_FULL,
                   result_o.entry_count == CapLow)

endmodule
